@@ hdl/imt_pkg.sv @@
// Shared types, character codes and style masks for the inline markup tokenizer.
// No dependencies; the design files and the testbench refer to names here by imt_pkg:: scope.
`timescale 1ns / 1ps
`default_nettype none
package imt_pkg;

  localparam int MaxResults = 3;

  // Character codes
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_UNDER = 8'h5F;
  localparam logic [7:0] CH_TILDE = 8'h7E;
  localparam logic [7:0] CH_CARET = 8'h5E;
  localparam logic [7:0] CH_SPACE = 8'h20;

  // Style flag masks: bit 0 bold .. bit 6 superscript
  localparam logic [6:0] FLAG_BOLD = 7'h01;
  localparam logic [6:0] FLAG_EMPH = 7'h02;
  localparam logic [6:0] FLAG_ITAL = 7'h04;
  localparam logic [6:0] FLAG_UNDL = 7'h08;
  localparam logic [6:0] FLAG_SUB  = 7'h10;
  localparam logic [6:0] FLAG_STRK = 7'h20;
  localparam logic [6:0] FLAG_SUP  = 7'h40;

  typedef enum logic [2:0] {
    PEND_NONE  = 3'd0,
    PEND_NL    = 3'd1,
    PEND_STAR  = 3'd2,
    PEND_UNDER = 3'd3,
    PEND_TILDE = 3'd4
  } imt_pend_t;

  typedef enum logic [1:0] {
    KIND_TEXT = 2'd0,
    KIND_PARA = 2'd1,
    KIND_END  = 2'd2
  } imt_kind_t;

  typedef struct packed {
    imt_pend_t  pending;
    logic [6:0] flags;
    logic       new_segment;
  } imt_state_t;

  typedef struct packed {
    imt_kind_t  kind;
    logic [7:0] char_code;
    logic       segment_start;
    logic [6:0] flags;
  } imt_result_t;

  typedef imt_result_t [MaxResults-1:0] imt_res_vec_t;

  // Byte that completes a double marker; codes with no partner never match.
  function automatic logic [8:0] pend_char(input imt_pend_t p);
    unique case (p)
      PEND_NL:    pend_char = {1'b0, CH_NL};
      PEND_STAR:  pend_char = {1'b0, CH_STAR};
      PEND_UNDER: pend_char = {1'b0, CH_UNDER};
      PEND_TILDE: pend_char = {1'b0, CH_TILDE};
      default:    pend_char = 9'h100;
    endcase
  endfunction

endpackage
`default_nettype wire

@@ hdl/imt_if.sv @@
// Valid/ready channel interfaces for the tokenizer input bytes and result beats.
// Depends on nothing; payload widths follow the field list.
`timescale 1ns / 1ps
`default_nettype none
interface imt_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_in;
  logic       last_byte;

  modport source (output valid, output byte_in, output last_byte, input ready);
  modport sink   (input valid, input byte_in, input last_byte, output ready);
endinterface

interface imt_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] char_code;
  logic       segment_start;
  logic       bold;
  logic       emphatic;
  logic       italic;
  logic       underlined;
  logic       subscript;
  logic       struck;
  logic       superscript;
  logic       run_end;

  modport source (output valid, output kind, output char_code, output segment_start,
                  output bold, output emphatic, output italic, output underlined,
                  output subscript, output struck, output superscript, output run_end,
                  input ready);
  modport sink   (input valid, input kind, input char_code, input segment_start,
                  input bold, input emphatic, input italic, input underlined,
                  input subscript, input struck, input superscript, input run_end,
                  output ready);
endinterface
`default_nettype wire

@@ hdl/inline_markup_tokenizer.sv @@
// First result beat of a byte is valid the cycle after the byte is taken.
// Throughput: one byte per cycle while bytes give at most one beat and out_ch is
// ready; the single result port holds the input until a byte's beats drain.
// Reset (rst, synchronous): no marker pending, all style flags clear, next text
// character starts a segment, result buffer empty.
`timescale 1ns / 1ps
`default_nettype none
module inline_markup_tokenizer (
  input  var logic    clk,
  input  var logic    rst,
  imt_in_if.sink      in_ch,
  imt_out_if.source   out_ch
);

  // Tokenizer state carried from byte to byte
  imt_pkg::imt_state_t   state;
  imt_pkg::imt_state_t   state_next;

  // Result buffer: beats of the last accepted byte, head at index 0
  imt_pkg::imt_res_vec_t batch;
  logic [1:0]            left;

  imt_pkg::imt_res_vec_t step_res;
  logic [1:0]            step_cnt;

  logic in_acc;
  logic out_acc;

  imt_step u_step (
    .state      (state),
    .byte_in    (in_ch.byte_in),
    .last_byte  (in_ch.last_byte),
    .state_next (state_next),
    .results    (step_res),
    .count      (step_cnt)
  );

  // Take a new byte when the buffer is empty or drains its final beat now.
  assign in_ch.ready = (left == 2'd0) || ((left == 2'd1) && out_ch.ready);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign out_acc     = out_ch.valid && out_ch.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '{imt_pkg::PEND_NONE, 7'h00, 1'b1};
      left  <= 2'd0;
    end else begin
      if (in_acc) begin
        state <= state_next;
        left  <= step_cnt;
      end else if (out_acc) begin
        left  <= left - 2'd1;
      end
    end
  end

  // Payload: load on a new byte, otherwise shift up one beat per handshake
  always_ff @(posedge clk) begin
    if (in_acc) begin
      batch <= step_res;
    end else if (out_acc) begin
      batch[0] <= batch[1];
      batch[1] <= batch[2];
    end
  end

  assign out_ch.valid         = (left != 2'd0);
  assign out_ch.kind          = batch[0].kind;
  assign out_ch.char_code     = batch[0].char_code;
  assign out_ch.segment_start = batch[0].segment_start;
  assign out_ch.bold          = batch[0].flags[0];
  assign out_ch.emphatic      = batch[0].flags[1];
  assign out_ch.italic        = batch[0].flags[2];
  assign out_ch.underlined    = batch[0].flags[3];
  assign out_ch.subscript     = batch[0].flags[4];
  assign out_ch.struck        = batch[0].flags[5];
  assign out_ch.superscript   = batch[0].flags[6];
  // Last beat of the byte closes the run
  assign out_ch.run_end       = (left == 2'd1);

  // A last byte always restores the start-of-text state
  a_last_resets: assert property (@(posedge clk) disable iff (rst)
    in_acc && in_ch.last_byte |=> state.pending == imt_pkg::PEND_NONE
      && state.flags == 7'h00 && state.new_segment)
    else $error("state not restored after last byte");

  // A last byte always leaves at least its end beat to deliver
  a_last_has_beats: assert property (@(posedge clk) disable iff (rst)
    in_acc && in_ch.last_byte |=> out_ch.valid)
    else $error("no result after last byte");

  // Input stays closed while more than one beat is queued
  a_hold_input: assert property (@(posedge clk) disable iff (rst)
    left > 2'd1 |-> !in_ch.ready)
    else $error("input open with beats queued");

  // End of text is always the final beat of its byte
  a_end_closes: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && out_ch.kind == imt_pkg::KIND_END |-> out_ch.run_end)
    else $error("end beat not last of run");

endmodule
`default_nettype wire

@@ hdl/imt_step.sv @@
// Per-byte tokenizer logic: resolves the pending marker, handles the new byte,
// closes the text on the last byte. Pure combinational; uses imt_pkg.
`timescale 1ns / 1ps
`default_nettype none
module imt_step (
  input  var imt_pkg::imt_state_t   state,
  input  var logic [7:0]            byte_in,
  input  var logic                  last_byte,
  output var imt_pkg::imt_state_t   state_next,
  output var imt_pkg::imt_res_vec_t results,
  output var logic [1:0]            count
);

  imt_pkg::imt_pend_t pm;
  logic [6:0]         fl;
  logic               sg;
  logic [1:0]         cnt;
  logic               consumed;
  imt_pkg::imt_res_vec_t res;

  always_comb begin
    pm       = state.pending;
    fl       = state.flags;
    sg       = state.new_segment;
    cnt      = 2'd0;
    consumed = 1'b0;
    res      = '0;

    // Pending marker against the new byte
    if (pm != imt_pkg::PEND_NONE) begin
      if ({1'b0, byte_in} == imt_pkg::pend_char(pm)) begin
        consumed = 1'b1;
        unique case (pm)
          imt_pkg::PEND_NL: begin
            res[cnt] = '{imt_pkg::KIND_PARA, 8'h00, 1'b0, fl};
            cnt      = cnt + 2'd1;
            sg       = 1'b1;
          end
          imt_pkg::PEND_STAR: begin
            fl = fl ^ imt_pkg::FLAG_EMPH;
            sg = 1'b1;
          end
          imt_pkg::PEND_UNDER: begin
            fl = fl ^ imt_pkg::FLAG_UNDL;
            sg = 1'b1;
          end
          imt_pkg::PEND_TILDE: begin
            fl = fl ^ imt_pkg::FLAG_STRK;
            sg = 1'b1;
          end
          default: ;
        endcase
      end else begin
        unique case (pm)
          imt_pkg::PEND_NL: begin
            res[cnt] = '{imt_pkg::KIND_TEXT, imt_pkg::CH_SPACE, sg, fl};
            cnt      = cnt + 2'd1;
            sg       = 1'b0;
          end
          imt_pkg::PEND_STAR: begin
            fl = fl ^ imt_pkg::FLAG_BOLD;
            sg = 1'b1;
          end
          imt_pkg::PEND_UNDER: begin
            fl = fl ^ imt_pkg::FLAG_ITAL;
            sg = 1'b1;
          end
          imt_pkg::PEND_TILDE: begin
            fl = fl ^ imt_pkg::FLAG_SUB;
            sg = 1'b1;
          end
          default: ;
        endcase
      end
    end
    pm = imt_pkg::PEND_NONE;

    // The byte itself
    if (!consumed) begin
      case (byte_in)
        imt_pkg::CH_NL:    pm = imt_pkg::PEND_NL;
        imt_pkg::CH_STAR:  pm = imt_pkg::PEND_STAR;
        imt_pkg::CH_UNDER: pm = imt_pkg::PEND_UNDER;
        imt_pkg::CH_TILDE: pm = imt_pkg::PEND_TILDE;
        imt_pkg::CH_CARET: begin
          fl = fl ^ imt_pkg::FLAG_SUP;
          sg = 1'b1;
        end
        default: begin
          res[cnt] = '{imt_pkg::KIND_TEXT, byte_in, sg, fl};
          cnt      = cnt + 2'd1;
          sg       = 1'b0;
        end
      endcase
    end

    // End of text: single-resolve what is left, then the end beat
    if (last_byte) begin
      unique case (pm)
        imt_pkg::PEND_NL: begin
          res[cnt] = '{imt_pkg::KIND_TEXT, imt_pkg::CH_SPACE, sg, fl};
          cnt      = cnt + 2'd1;
        end
        imt_pkg::PEND_STAR:  fl = fl ^ imt_pkg::FLAG_BOLD;
        imt_pkg::PEND_UNDER: fl = fl ^ imt_pkg::FLAG_ITAL;
        imt_pkg::PEND_TILDE: fl = fl ^ imt_pkg::FLAG_SUB;
        default: ;
      endcase
      res[cnt] = '{imt_pkg::KIND_END, 8'h00, 1'b0, fl};
      cnt      = cnt + 2'd1;
      pm       = imt_pkg::PEND_NONE;
      fl       = 7'h00;
      sg       = 1'b1;
    end

    state_next = '{pm, fl, sg};
    results    = res;
    count      = cnt;
  end

endmodule
`default_nettype wire

@@ tb/imt_checker.sv @@
// Checker for the inline markup tokenizer: watches both channels, predicts result beats.
// Depends on imt_pkg and the imt_in_if / imt_out_if interfaces.
`timescale 1ns / 1ps
module imt_checker (
  input  logic clk,
  input  logic rst,
  imt_in_if    in_mon,
  imt_out_if   out_mon,
  output int   errors,
  output int   outstanding
);

  typedef struct packed {
    imt_pkg::imt_kind_t kind;
    logic [7:0]         char_code;
    logic               seg;
    logic [6:0]         flags;
    logic               run_end;
  } beat_t;

  beat_t expected_beats[$];
  beat_t batch[$];

  // Tokenizer state as predicted
  imt_pkg::imt_pend_t pend;
  logic [6:0]         style;
  logic               fresh;

  int mismatches = 0;
  int waiting = 0;

  string flag_names [7] = '{"bold", "emphatic", "italic", "underlined",
                            "subscript", "struck", "superscript"};

  assign errors = mismatches;
  assign outstanding = waiting;

  task automatic clear_text_state();
    pend = imt_pkg::PEND_NONE;
    style = '0;
    fresh = 1'b1;
  endtask

  task automatic add_beat(input imt_pkg::imt_kind_t k, input logic [7:0] c, input logic s);
    beat_t nb;
    nb.kind = k;
    nb.char_code = c;
    nb.seg = s;
    nb.flags = style;
    nb.run_end = 1'b0;
    batch.insert(batch.size(), nb);
  endtask

  task automatic add_char(input logic [7:0] c);
    add_beat(imt_pkg::KIND_TEXT, c, fresh);
    fresh = 1'b0;
  endtask

  task automatic flip(input logic [6:0] m);
    style ^= m;
    fresh = 1'b1;
  endtask

  // Held marker did not pair up: settle it as a single.
  task automatic settle_single();
    case (pend)
      imt_pkg::PEND_NL:    add_char(imt_pkg::CH_SPACE);
      imt_pkg::PEND_STAR:  flip(imt_pkg::FLAG_BOLD);
      imt_pkg::PEND_UNDER: flip(imt_pkg::FLAG_ITAL);
      imt_pkg::PEND_TILDE: flip(imt_pkg::FLAG_SUB);
      default: ;
    endcase
    pend = imt_pkg::PEND_NONE;
  endtask

  task automatic tokenize_byte(input logic [7:0] b, input logic last);
    logic       paired;
    logic [8:0] partner;
    paired = 1'b0;
    batch.delete();
    case (pend)
      imt_pkg::PEND_NL:    partner = {1'b0, imt_pkg::CH_NL};
      imt_pkg::PEND_STAR:  partner = {1'b0, imt_pkg::CH_STAR};
      imt_pkg::PEND_UNDER: partner = {1'b0, imt_pkg::CH_UNDER};
      imt_pkg::PEND_TILDE: partner = {1'b0, imt_pkg::CH_TILDE};
      default:             partner = 9'h100;
    endcase
    if (pend != imt_pkg::PEND_NONE) begin
      if ({1'b0, b} == partner) begin
        case (pend)
          imt_pkg::PEND_NL: begin
            add_beat(imt_pkg::KIND_PARA, 8'h00, 1'b0);
            fresh = 1'b1;
          end
          imt_pkg::PEND_STAR:  flip(imt_pkg::FLAG_EMPH);
          imt_pkg::PEND_UNDER: flip(imt_pkg::FLAG_UNDL);
          imt_pkg::PEND_TILDE: flip(imt_pkg::FLAG_STRK);
          default: ;
        endcase
        pend = imt_pkg::PEND_NONE;
        paired = 1'b1;
      end else begin
        settle_single();
      end
    end
    if (!paired) begin
      case (b)
        imt_pkg::CH_NL:    pend = imt_pkg::PEND_NL;
        imt_pkg::CH_STAR:  pend = imt_pkg::PEND_STAR;
        imt_pkg::CH_UNDER: pend = imt_pkg::PEND_UNDER;
        imt_pkg::CH_TILDE: pend = imt_pkg::PEND_TILDE;
        imt_pkg::CH_CARET: flip(imt_pkg::FLAG_SUP);
        default:           add_char(b);
      endcase
    end
    if (last) begin
      settle_single();
      add_beat(imt_pkg::KIND_END, 8'h00, 1'b0);
      clear_text_state();
    end
    if (batch.size() > 0) batch[batch.size() - 1].run_end = 1'b1;
    foreach (batch[i]) expected_beats.insert(expected_beats.size(), batch[i]);
  endtask

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    beat_t got;
    beat_t want;
    if (rst) begin
      clear_text_state();
      expected_beats.delete();
    end else begin
      if (in_mon.valid && in_mon.ready) tokenize_byte(in_mon.byte_in, in_mon.last_byte);
      if (out_mon.valid && out_mon.ready) begin
        got.kind = imt_pkg::imt_kind_t'(out_mon.kind);
        got.char_code = out_mon.char_code;
        got.seg = out_mon.segment_start;
        got.flags = {out_mon.superscript, out_mon.struck, out_mon.subscript,
                     out_mon.underlined, out_mon.italic, out_mon.emphatic, out_mon.bold};
        got.run_end = out_mon.run_end;
        if (expected_beats.size() == 0) begin
          $display("%0t: unexpected beat, expected none, actual kind %0d char %0d",
                   $time, got.kind, got.char_code);
          mismatches++;
        end else begin
          want = expected_beats.pop_front();
          check_field("kind", 8'(want.kind), 8'(got.kind));
          check_field("char_code", want.char_code, got.char_code);
          check_field("segment_start", 8'(want.seg), 8'(got.seg));
          for (int i = 0; i < 7; i++) check_field(flag_names[i], 8'(want.flags[i]),
                                                   8'(got.flags[i]));
          check_field("run_end", 8'(want.run_end), 8'(got.run_end));
        end
      end
    end
    waiting = expected_beats.size();
  end

endmodule

@@ tb/inline_markup_tokenizer_tb.sv @@
// Top of the inline markup tokenizer testbench: clock, reset, byte stimulus, result
// back-pressure and verdict. Depends on imt_pkg, the channel interfaces and imt_checker.
`timescale 1ns / 1ps
module inline_markup_tokenizer_tb;

  localparam int CycleLimit  = 200000;
  localparam int RandomItems = 155;
  localparam int NumDirected = 25;

  // Directed texts, each entry {last_byte, byte_in}:
  //   extremes 00/FF, caret, other markers single and double, lone and double newline,
  //   paragraph break right before a marker, marker pending on the final byte,
  //   a lone newline as the final byte, a double marker closing on the final byte.
  localparam logic [8:0] DIRECTED [NumDirected] = '{
    {1'b0, 8'h00},              {1'b0, imt_pkg::CH_STAR},
    {1'b0, imt_pkg::CH_STAR},   {1'b0, 8'h41},
    {1'b0, imt_pkg::CH_UNDER},  {1'b0, 8'h62},
    {1'b0, imt_pkg::CH_UNDER},  {1'b0, imt_pkg::CH_UNDER},
    {1'b0, imt_pkg::CH_TILDE},  {1'b0, 8'hFF},
    {1'b0, imt_pkg::CH_TILDE},  {1'b0, imt_pkg::CH_TILDE},
    {1'b0, imt_pkg::CH_CARET},  {1'b0, 8'h63},
    {1'b0, imt_pkg::CH_NL},     {1'b0, 8'h64},
    {1'b0, imt_pkg::CH_NL},     {1'b0, imt_pkg::CH_NL},
    {1'b0, imt_pkg::CH_STAR},   {1'b0, 8'h65},
    {1'b1, imt_pkg::CH_STAR},
    {1'b1, imt_pkg::CH_NL},
    {1'b0, imt_pkg::CH_TILDE},  {1'b1, imt_pkg::CH_TILDE},
    {1'b1, imt_pkg::CH_CARET}
  };

  logic clk;
  logic rst = 1'b1;

  // Shared knobs: idle_en turns random idling on both sides on or off;
  // hold_req asks the receiver for one long hold-off, hold_done reports its end.
  logic idle_en = 1'b1;
  logic hold_req = 1'b0;
  logic hold_done = 1'b0;

  int fail_count;
  int pending_beats;
  int cycles = 0;
  int sent = 0;

  imt_in_if  in_bus ();
  imt_out_if out_bus ();

  inline_markup_tokenizer DUT (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_bus),
    .out_ch (out_bus)
  );

  imt_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .in_mon      (in_bus),
    .out_mon     (out_bus),
    .errors      (fail_count),
    .outstanding (pending_beats)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Offer one byte beat. Entered and left at a falling edge; valid stays high
  // across back-to-back beats, so it only gets one assignment per step.
  task automatic send_byte(input logic [7:0] b, input logic last);
    while (idle_en && $urandom_range(0, 99) < 36) begin
      in_bus.valid <= 1'b0;
      @(negedge clk);
    end
    in_bus.valid     <= 1'b1;
    in_bus.byte_in   <= b;
    in_bus.last_byte <= last;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
    @(negedge clk);
    sent++;
  endtask

  // One short text ending on last_byte. Mostly markup-heavy content so that
  // markers pair, split and dangle; noise texts are raw bytes with stray ends.
  task automatic send_random_text(input bit noise);
    int         len;
    int         pick;
    logic [7:0] b;
    logic       last;
    len = $urandom_range(1, 12);
    for (int i = 0; i < len; i++) begin
      pick = $urandom_range(0, 99);
      if (noise || pick < 15) b = 8'($urandom_range(0, 255));
      else if (pick < 30) b = imt_pkg::CH_STAR;
      else if (pick < 40) b = imt_pkg::CH_UNDER;
      else if (pick < 50) b = imt_pkg::CH_TILDE;
      else if (pick < 56) b = imt_pkg::CH_CARET;
      else if (pick < 70) b = imt_pkg::CH_NL;
      else b = 8'($urandom_range(8'h61, 8'h7A));
      last = (i == len - 1) || (noise && $urandom_range(0, 7) == 0);
      send_byte(b, last);
    end
  endtask

  // Result side: random stalls, plus one long hold-off counted here so that
  // the block's buffer fills and the input backs up.
  initial begin
    out_bus.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req && !hold_done) begin
        out_bus.ready <= 1'b0;
        repeat (150) @(negedge clk);
        hold_done = 1'b1;
      end else begin
        out_bus.ready <= !(idle_en && $urandom_range(0, 99) < 36);
      end
    end
  end

  initial begin
    in_bus.valid     = 1'b0;
    in_bus.byte_in   = 8'h00;
    in_bus.last_byte = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (int i = 0; i < NumDirected; i++) send_byte(DIRECTED[i][7:0], DIRECTED[i][8]);

    // Random texts with idling on both sides
    while (sent < NumDirected + 80) send_random_text($urandom_range(0, 9) == 0);

    // Stretch with no idling at all
    idle_en = 1'b0;
    while (sent < NumDirected + 120) send_random_text($urandom_range(0, 9) == 0);

    // Long receiver hold-off while bytes keep coming
    hold_req = 1'b1;
    while (!hold_done) send_random_text($urandom_range(0, 9) == 0);
    hold_req = 1'b0;

    idle_en = 1'b1;
    while (sent < NumDirected + RandomItems) send_random_text($urandom_range(0, 9) == 0);
    in_bus.valid <= 1'b0;

    // Drain the expected beats, then wait out anything stray
    while (pending_beats != 0) @(negedge clk);
    repeat (10) @(negedge clk);

    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

@@ inline_markup_tokenizer.f @@
hdl/imt_pkg.sv
hdl/imt_if.sv
hdl/imt_step.sv
hdl/inline_markup_tokenizer.sv
tb/imt_checker.sv
tb/inline_markup_tokenizer_tb.sv
